[hdl/ngrfe_pkg.sv]
// ============================================================================
// ngrfe_pkg: shared types and constants for the NMEA GGA/RMC field extractor
// Character codes, field maps, number tables and the field hand-off record.
// ============================================================================
package ngrfe_pkg;

    // Fraction digits honored by the number reader, and the part of them that
    // can still change a result (three for decimals, seven for coordinates).
    localparam int FRAC_DIGITS = 7;
    localparam int FRAC_KEEP   = (FRAC_DIGITS < 7) ? FRAC_DIGITS : 7;

    localparam logic [33:0] WHOLE_CAP = 34'h3_FFFF_FFFF;

    // Character codes
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Quantity codes
    localparam logic [3:0] QTY_TIME     = 4'd0;
    localparam logic [3:0] QTY_VALID    = 4'd1;
    localparam logic [3:0] QTY_LAT      = 4'd2;
    localparam logic [3:0] QTY_LATDIR   = 4'd3;
    localparam logic [3:0] QTY_LNG      = 4'd4;
    localparam logic [3:0] QTY_LNGDIR   = 4'd5;
    localparam logic [3:0] QTY_SPEED    = 4'd6;
    localparam logic [3:0] QTY_HEADING  = 4'd7;
    localparam logic [3:0] QTY_DATE     = 4'd8;
    localparam logic [3:0] QTY_QUALITY  = 4'd9;
    localparam logic [3:0] QTY_SATS     = 4'd10;
    localparam logic [3:0] QTY_HDOP     = 4'd11;
    localparam logic [3:0] QTY_ALT      = 4'd12;
    localparam logic [3:0] QTY_DIFFAGE  = 4'd13;

    // Configuration register indexes and reset values
    localparam logic [1:0] CFG_LAT_LOW  = 2'd0;
    localparam logic [1:0] CFG_LAT_HIGH = 2'd1;
    localparam logic [1:0] CFG_LNG_LOW  = 2'd2;
    localparam logic [1:0] CFG_LNG_HIGH = 2'd3;

    localparam logic [6:0] LAT_LOW_RST  = 7'd8;
    localparam logic [6:0] LAT_HIGH_RST = 7'd37;
    localparam logic [7:0] LNG_LOW_RST  = 8'd68;
    localparam logic [7:0] LNG_HIGH_RST = 8'd97;

    typedef enum logic [2:0] {
        CONV_NONE,
        CONV_INT,
        CONV_DEC,
        CONV_FLAG,
        CONV_LAT,
        CONV_LNG
    } conv_t;

    typedef struct packed {
        conv_t      conv;
        logic [3:0] qty;
    } fmap_t;

    // One finished field, handed from the parser to the converter
    typedef struct packed {
        logic        is_rmc;
        logic [3:0]  qty;
        conv_t       conv;
        logic        minus;
        logic [7:0]  lead;
        logic [33:0] whole;
        logic [9:0]  frac3;
        logic [23:0] frac7;
    } ngrfe_field_t;

    // Coordinate degree windows
    typedef struct packed {
        logic [6:0] lat_low;
        logic [6:0] lat_high;
        logic [7:0] lng_low;
        logic [7:0] lng_high;
    } ngrfe_limits_t;

    function automatic logic [7:0] gga_char(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = 8'h47; // G
            3'd1:    ch = 8'h4E; // N
            3'd2:    ch = 8'h47; // G
            3'd3:    ch = 8'h47; // G
            3'd4:    ch = 8'h41; // A
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] rmc_char(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = 8'h47; // G
            3'd1:    ch = 8'h4E; // N
            3'd2:    ch = 8'h52; // R
            3'd3:    ch = 8'h4D; // M
            3'd4:    ch = 8'h43; // C
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Field position to conversion and quantity
    function automatic fmap_t field_map(input logic is_rmc, input logic [3:0] idx);
        fmap_t m;
        m = '{conv: CONV_NONE, qty: QTY_TIME};
        if (is_rmc) begin
            unique case (idx)
                4'd1:    m = '{conv: CONV_INT,  qty: QTY_TIME};
                4'd2:    m = '{conv: CONV_FLAG, qty: QTY_VALID};
                4'd3:    m = '{conv: CONV_LAT,  qty: QTY_LAT};
                4'd4:    m = '{conv: CONV_FLAG, qty: QTY_LATDIR};
                4'd5:    m = '{conv: CONV_LNG,  qty: QTY_LNG};
                4'd6:    m = '{conv: CONV_FLAG, qty: QTY_LNGDIR};
                4'd7:    m = '{conv: CONV_DEC,  qty: QTY_SPEED};
                4'd8:    m = '{conv: CONV_DEC,  qty: QTY_HEADING};
                4'd9:    m = '{conv: CONV_INT,  qty: QTY_DATE};
                default: m = '{conv: CONV_NONE, qty: QTY_TIME};
            endcase
        end else begin
            unique case (idx)
                4'd1:    m = '{conv: CONV_INT,  qty: QTY_TIME};
                4'd2:    m = '{conv: CONV_LAT,  qty: QTY_LAT};
                4'd3:    m = '{conv: CONV_FLAG, qty: QTY_LATDIR};
                4'd4:    m = '{conv: CONV_LNG,  qty: QTY_LNG};
                4'd5:    m = '{conv: CONV_FLAG, qty: QTY_LNGDIR};
                4'd6:    m = '{conv: CONV_INT,  qty: QTY_QUALITY};
                4'd7:    m = '{conv: CONV_INT,  qty: QTY_SATS};
                4'd8:    m = '{conv: CONV_DEC,  qty: QTY_HDOP};
                4'd9:    m = '{conv: CONV_DEC,  qty: QTY_ALT};
                4'd13:   m = '{conv: CONV_INT,  qty: QTY_DIFFAGE};
                default: m = '{conv: CONV_NONE, qty: QTY_TIME};
            endcase
        end
        return m;
    endfunction

    // Weight of a fraction digit in the seven-digit fraction
    function automatic logic [23:0] frac7_weight(input logic [2:0] pos, input logic [3:0] d);
        logic [23:0] w;
        unique case (pos)
            3'd0:    w = 24'd1000000;
            3'd1:    w = 24'd100000;
            3'd2:    w = 24'd10000;
            3'd3:    w = 24'd1000;
            3'd4:    w = 24'd100;
            3'd5:    w = 24'd10;
            3'd6:    w = 24'd1;
            default: w = 24'd0;
        endcase
        return w * {20'd0, d};
    endfunction

    // Weight of a fraction digit in the three-digit fraction
    function automatic logic [9:0] frac3_weight(input logic [2:0] pos, input logic [3:0] d);
        logic [9:0] w;
        unique case (pos)
            3'd0:    w = 10'd100;
            3'd1:    w = 10'd10;
            3'd2:    w = 10'd1;
            default: w = 10'd0;
        endcase
        return w * {6'd0, d};
    endfunction

    // Signed saturation of a magnitude
    function automatic logic [31:0] saturate(input logic [33:0] mag, input logic neg);
        logic [31:0] r;
        if (neg) begin
            if (mag >= 34'h0_8000_0000) r = 32'h8000_0000;
            else                        r = 32'd0 - mag[31:0];
        end else begin
            if (mag > 34'h0_7FFF_FFFF)  r = 32'h7FFF_FFFF;
            else                        r = mag[31:0];
        end
        return r;
    endfunction

endpackage

[hdl/ngrfe_conv.sv]
// ============================================================================
// ngrfe_conv: field value converter
// Four-stage pipeline that turns a finished field into its result item.
// ============================================================================
module ngrfe_conv (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  ngrfe_pkg::ngrfe_field_t  in_field,
    input  ngrfe_pkg::ngrfe_limits_t limits,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [39:0]              m_tdata   // sentence_kind, quantity[3:0], field_value[31:0]
);
    import ngrfe_pkg::*;

    logic        v2_reg, v3_reg, v4_reg, out_v_reg;
    logic        rdy2, rdy3, rdy4, rdy_out;

    // stage 2: degrees, window, simple values
    logic        rmc2_reg;
    logic [3:0]  qty2_reg;
    conv_t       conv2_reg;
    logic [31:0] simple2_reg;
    logic        ok2_reg;
    logic [7:0]  deg2_reg;
    logic [14:0] w2_reg;
    logic [23:0] frac7_2_reg;

    // stage 3: minutes in 1e-7 units
    logic        rmc3_reg;
    logic [3:0]  qty3_reg;
    conv_t       conv3_reg;
    logic [31:0] simple3_reg;
    logic        ok3_reg;
    logic [7:0]  deg3_reg;
    logic [29:0] y3_reg;

    // stage 4: minutes over sixty
    logic        rmc4_reg;
    logic [3:0]  qty4_reg;
    conv_t       conv4_reg;
    logic [31:0] simple4_reg;
    logic        ok4_reg;
    logic [7:0]  deg4_reg;
    logic [24:0] q4_reg;

    // result register
    logic        out_rmc_reg;
    logic [3:0]  out_qty_reg;
    logic [31:0] out_value_reg;

    // stage 2 logic
    logic [7:0]  low2, high2;
    logic        big2;
    logic [27:0] degp2;
    logic [7:0]  deg2_next;
    logic        ok2_next;
    logic        dec_big2;
    logic [31:0] dec_sum2;
    logic [33:0] dec_mag2;
    logic [31:0] simple2_next;

    // later stages
    logic [14:0] rem15;
    logic [29:0] y3_next;
    logic [56:0] prod4;
    logic [31:0] mag_out;
    logic [31:0] coord_out;
    logic [31:0] value_next;

    // Ready chain from the result register back to the input
    assign rdy_out  = !out_v_reg || m_tready;
    assign rdy4     = !v4_reg || rdy_out;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign in_ready = rdy2;

    // Degrees by reciprocal of 100, window check, integer and decimal values
    always_comb begin
        if (in_field.conv == CONV_LAT) begin
            low2  = {1'b0, limits.lat_low};
            high2 = {1'b0, limits.lat_high};
        end else begin
            low2  = limits.lng_low;
            high2 = limits.lng_high;
        end
        big2      = in_field.whole >= 34'd25600;
        degp2     = {13'd0, in_field.whole[14:0]} * 28'd5243;
        deg2_next = degp2[26:19];
        ok2_next  = !big2 && !in_field.minus && (deg2_next > low2) && (deg2_next < high2);

        dec_big2  = |in_field.whole[33:22];
        dec_sum2  = {10'd0, in_field.whole[21:0]} * 32'd1000 + {22'd0, in_field.frac3};
        dec_mag2  = dec_big2 ? 34'h1_0000_0000 : {2'b00, dec_sum2};

        unique case (in_field.conv)
            CONV_INT:  simple2_next = saturate(in_field.whole, in_field.minus);
            CONV_DEC:  simple2_next = saturate(dec_mag2, in_field.minus);
            CONV_FLAG: simple2_next = {24'd0, in_field.lead};
            default:   simple2_next = 32'd0;
        endcase
    end

    // Remainder minutes, scaled and joined with the fraction
    always_comb begin
        rem15   = w2_reg - ({7'd0, deg2_reg} * 15'd100);
        y3_next = ({23'd0, rem15[6:0]} * 30'd10000000) + {6'd0, frac7_2_reg};
    end

    // Divide by sixty: drop two bits, then multiply by the reciprocal of fifteen
    assign prod4 = {29'd0, y3_reg[29:2]} * 57'd286331154;

    // Whole degrees plus fraction, saturate, pick the value
    always_comb begin
        mag_out   = ({24'd0, deg4_reg} * 32'd10000000) + {7'd0, q4_reg};
        coord_out = ok4_reg ? saturate({2'b00, mag_out}, 1'b0) : 32'd0;
        if (conv4_reg == CONV_LAT || conv4_reg == CONV_LNG) value_next = coord_out;
        else                                                value_next = simple4_reg;
    end

    // Advance stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (rdy2)    v2_reg    <= in_valid;
            if (rdy3)    v3_reg    <= v2_reg;
            if (rdy4)    v4_reg    <= v3_reg;
            if (rdy_out) out_v_reg <= v4_reg;
        end
    end

    // Advance stage payloads
    always_ff @(posedge aclk) begin
        if (rdy2) begin
            rmc2_reg    <= in_field.is_rmc;
            qty2_reg    <= in_field.qty;
            conv2_reg   <= in_field.conv;
            simple2_reg <= simple2_next;
            ok2_reg     <= ok2_next;
            deg2_reg    <= deg2_next;
            w2_reg      <= in_field.whole[14:0];
            frac7_2_reg <= in_field.frac7;
        end
        if (rdy3) begin
            rmc3_reg    <= rmc2_reg;
            qty3_reg    <= qty2_reg;
            conv3_reg   <= conv2_reg;
            simple3_reg <= simple2_reg;
            ok3_reg     <= ok2_reg;
            deg3_reg    <= deg2_reg;
            y3_reg      <= y3_next;
        end
        if (rdy4) begin
            rmc4_reg    <= rmc3_reg;
            qty4_reg    <= qty3_reg;
            conv4_reg   <= conv3_reg;
            simple4_reg <= simple3_reg;
            ok4_reg     <= ok3_reg;
            deg4_reg    <= deg3_reg;
            q4_reg      <= prod4[56:32];
        end
        if (rdy_out) begin
            out_rmc_reg   <= rmc4_reg;
            out_qty_reg   <= qty4_reg;
            out_value_reg <= value_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {3'b000, out_value_reg, out_qty_reg, out_rmc_reg};

    // Coordinates are never negative
    a_coord_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        out_v_reg && (out_qty_reg == QTY_LAT || out_qty_reg == QTY_LNG)
        |-> !out_value_reg[31])
        else $error("coordinate result negative");

    // Flags carry one character code
    a_flag_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        out_v_reg && (out_qty_reg == QTY_VALID || out_qty_reg == QTY_LATDIR ||
                      out_qty_reg == QTY_LNGDIR)
        |-> (out_value_reg[31:8] == 24'd0))
        else $error("flag result wider than a character");

    // An accepted field enters the first stage
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> v2_reg)
        else $error("accepted field lost at pipeline entry");

    // A blocked last stage keeps its item
    a_hold4: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg && !rdy_out |=> v4_reg && $stable(q4_reg))
        else $error("stalled stage dropped its item");

endmodule

[hdl/nmea_gga_rmc_field_extractor.sv]
// ============================================================================
// nmea_gga_rmc_field_extractor: NMEA GGA/RMC field extractor
// Parses NMEA text a byte at a time and emits one item per mapped, non-empty
// field: sentence kind, quantity code and converted value.
// ============================================================================
//
//  Channel  Dir  Handshake          Payload
//  s_       in   s_tvalid/s_tready  s_tdata[7:0]  text byte
//  m_       out  m_tvalid/m_tready  m_tdata[39:0] kind, quantity, value
//  cfg_     in   cfg_wen            cfg_idx[1:0], cfg_wdata[7:0]
//
//  One byte is taken per cycle while s_tready is high. The byte that ends a
//  field is held in the field register, then passes the converter pipeline
//  stages (degree split, minutes scale, divide by sixty, sum) to the output.
//  Reset (aresetn low at a clock edge) clears the parser, the pipeline
//  valids and loads the default degree windows.
//  A stalled m_ side backs up through the pipeline registers; s_tready
//  drops only when the field register still holds an item.
//
module nmea_gga_rmc_field_extractor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // text_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // sentence_kind, quantity[3:0], field_value[31:0]
    input  logic        cfg_wen,
    input  logic [1:0]  cfg_idx,
    input  logic [7:0]  cfg_wdata
);
    import ngrfe_pkg::*;

    typedef enum logic [1:0] {
        KIND_IDLE,
        KIND_HEADER,
        KIND_GGA,
        KIND_RMC
    } kind_t;

    kind_t        kind_reg, kind_next;
    logic [2:0]   hpos_reg, hpos_next;
    logic [1:0]   cand_reg, cand_next;
    logic [3:0]   fnum_reg, fnum_next;
    logic [33:0]  whole_reg, whole_next;
    logic [9:0]   frac3_reg, frac3_next;
    logic [23:0]  frac7_reg, frac7_next;
    logic [2:0]   fcnt_reg, fcnt_next;
    logic         minus_reg, minus_next;
    logic         point_reg, point_next;
    logic         stop_reg, stop_next;
    logic [7:0]   lead_reg, lead_next;
    logic         nonempty_reg, nonempty_next;

    logic         snap_v_reg, snap_v_next;
    ngrfe_field_t snap_reg, snap_next;
    logic         conv_ready;

    ngrfe_limits_t limits_reg;

    logic [7:0]   c;
    logic         accept, delim, ends, is_digit, skip;
    logic [3:0]   d;
    logic [37:0]  whole_x10;
    fmap_t        fmap;
    logic         emit;

    assign c        = s_tdata;
    assign s_tready = !snap_v_reg || conv_ready;
    assign accept   = s_tvalid && s_tready;
    assign delim    = (c == CH_COMMA) || (c == CH_STAR) || (c == CH_CR) || (c == CH_LF);
    assign ends     = (c == CH_STAR) || (c == CH_CR) || (c == CH_LF);
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign d        = c[3:0];
    assign whole_x10 = {1'b0, whole_reg, 3'b000} + {3'b000, whole_reg, 1'b0} + {34'd0, d};
    assign fmap     = field_map(kind_reg == KIND_RMC, fnum_reg);

    // Parse one byte: header match, field collection, field end
    always_comb begin
        kind_next     = kind_reg;
        hpos_next     = hpos_reg;
        cand_next     = cand_reg;
        fnum_next     = fnum_reg;
        whole_next    = whole_reg;
        frac3_next    = frac3_reg;
        frac7_next    = frac7_reg;
        fcnt_next     = fcnt_reg;
        minus_next    = minus_reg;
        point_next    = point_reg;
        stop_next     = stop_reg;
        lead_next     = lead_reg;
        nonempty_next = nonempty_reg;
        emit          = 1'b0;
        skip          = 1'b0;

        snap_next        = '0;
        snap_next.is_rmc = (kind_reg == KIND_RMC);
        snap_next.qty    = fmap.qty;
        snap_next.conv   = fmap.conv;
        snap_next.minus  = minus_reg;
        snap_next.lead   = lead_reg;
        snap_next.whole  = whole_reg;
        snap_next.frac3  = frac3_reg;
        snap_next.frac7  = frac7_reg;

        if (accept) begin
            if (c == CH_DOLLAR) begin
                // open a sentence
                kind_next = KIND_HEADER;
                hpos_next = 3'd0;
                cand_next = 2'b11;
                fnum_next = 4'd0;
            end else begin
                unique case (kind_reg)
                    KIND_IDLE: begin
                    end
                    KIND_HEADER: begin
                        if (!delim) begin
                            if (hpos_reg < 3'd5) begin
                                if (c != gga_char(hpos_reg)) cand_next[0] = 1'b0;
                                if (c != rmc_char(hpos_reg)) cand_next[1] = 1'b0;
                                hpos_next = hpos_reg + 3'd1;
                            end else begin
                                // header too long
                                hpos_next = 3'd6;
                                cand_next = 2'b00;
                            end
                        end else begin
                            if (ends)                                kind_next = KIND_IDLE;
                            else if (hpos_reg == 3'd5 && cand_reg[0]) kind_next = KIND_GGA;
                            else if (hpos_reg == 3'd5 && cand_reg[1]) kind_next = KIND_RMC;
                            else                                     kind_next = KIND_IDLE;
                            fnum_next = 4'd1;
                        end
                    end
                    KIND_GGA, KIND_RMC: begin
                        if (!delim) begin
                            // take a character into the field
                            if (!nonempty_reg) begin
                                nonempty_next = 1'b1;
                                lead_next     = c;
                                if (c == CH_MINUS) begin
                                    minus_next = 1'b1;
                                    skip       = 1'b1;
                                end else if (c == CH_PLUS) begin
                                    skip = 1'b1;
                                end
                            end
                            if (!skip && !stop_reg) begin
                                if (is_digit) begin
                                    if (point_reg) begin
                                        if (fcnt_reg < 3'(FRAC_KEEP)) begin
                                            frac7_next = frac7_reg + frac7_weight(fcnt_reg, d);
                                            frac3_next = frac3_reg + frac3_weight(fcnt_reg, d);
                                            fcnt_next  = fcnt_reg + 3'd1;
                                        end
                                    end else if (whole_x10 > {4'd0, WHOLE_CAP}) begin
                                        whole_next = WHOLE_CAP;
                                    end else begin
                                        whole_next = whole_x10[33:0];
                                    end
                                end else if (c == CH_POINT && !point_reg) begin
                                    point_next = 1'b1;
                                end else begin
                                    stop_next = 1'b1;
                                end
                            end
                        end else begin
                            // end the field
                            emit = (fmap.conv != CONV_NONE) && nonempty_reg;
                            if (fnum_reg != 4'hF) fnum_next = fnum_reg + 4'd1;
                            if (ends) kind_next = KIND_IDLE;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // clear field collection at sentence start and every field end
            if (c == CH_DOLLAR || (kind_reg != KIND_IDLE && delim)) begin
                whole_next    = 34'd0;
                frac3_next    = 10'd0;
                frac7_next    = 24'd0;
                fcnt_next     = 3'd0;
                minus_next    = 1'b0;
                point_next    = 1'b0;
                stop_next     = 1'b0;
                lead_next     = 8'd0;
                nonempty_next = 1'b0;
            end
        end

        // hold the field register until the converter takes it
        if (accept && emit)               snap_v_next = 1'b1;
        else if (snap_v_reg && conv_ready) snap_v_next = 1'b0;
        else                              snap_v_next = snap_v_reg;
    end

    // Parser state and field register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg     <= KIND_IDLE;
            hpos_reg     <= 3'd0;
            cand_reg     <= 2'b00;
            fnum_reg     <= 4'd0;
            whole_reg    <= 34'd0;
            frac3_reg    <= 10'd0;
            frac7_reg    <= 24'd0;
            fcnt_reg     <= 3'd0;
            minus_reg    <= 1'b0;
            point_reg    <= 1'b0;
            stop_reg     <= 1'b0;
            lead_reg     <= 8'd0;
            nonempty_reg <= 1'b0;
            snap_v_reg   <= 1'b0;
        end else begin
            kind_reg     <= kind_next;
            hpos_reg     <= hpos_next;
            cand_reg     <= cand_next;
            fnum_reg     <= fnum_next;
            whole_reg    <= whole_next;
            frac3_reg    <= frac3_next;
            frac7_reg    <= frac7_next;
            fcnt_reg     <= fcnt_next;
            minus_reg    <= minus_next;
            point_reg    <= point_next;
            stop_reg     <= stop_next;
            lead_reg     <= lead_next;
            nonempty_reg <= nonempty_next;
            snap_v_reg   <= snap_v_next;
        end
    end

    // Load the field register on an emitting field end
    always_ff @(posedge aclk) begin
        if (accept && emit) snap_reg <= snap_next;
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limits_reg.lat_low  <= LAT_LOW_RST;
            limits_reg.lat_high <= LAT_HIGH_RST;
            limits_reg.lng_low  <= LNG_LOW_RST;
            limits_reg.lng_high <= LNG_HIGH_RST;
        end else if (cfg_wen) begin
            unique case (cfg_idx)
                CFG_LAT_LOW:  limits_reg.lat_low  <= cfg_wdata[6:0];
                CFG_LAT_HIGH: limits_reg.lat_high <= cfg_wdata[6:0];
                CFG_LNG_LOW:  limits_reg.lng_low  <= cfg_wdata;
                CFG_LNG_HIGH: limits_reg.lng_high <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    ngrfe_conv u_conv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (snap_v_reg),
        .in_ready (conv_ready),
        .in_field (snap_reg),
        .limits   (limits_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[test/tb_nmea_gga_rmc_field_extractor.sv]
// ============================================================================
// NMEA GGA/RMC field extractor testbench
// Streams directed and random NMEA text into the extractor, predicts every
// field result with an independent parser model, and checks each output item
// in order against it, with random idling on both sides and one long stall.
// ============================================================================
`timescale 1ns / 100ps

import ngrfe_pkg::*;

// Expected field results, oldest first
class field_scoreboard;
    logic [39:0] pending[$];
    int          errors;

    function new();
        errors = 0;
    endfunction

    function void note(logic [39:0] item);
        pending.push_back(item);
    endfunction

    function void check(logic [39:0] got);
        logic [39:0] want;
        if (pending.size() == 0) begin
            $error("unexpected result %h", got);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (want[0] !== got[0]) begin
            $error("sentence_kind expected %0d actual %0d", want[0], got[0]);
            errors++;
        end
        if (want[4:1] !== got[4:1]) begin
            $error("quantity expected %0d actual %0d", want[4:1], got[4:1]);
            errors++;
        end
        if (want[39:5] !== got[39:5]) begin
            $error("field_value expected %0d actual %0d",
                   $signed(want[36:5]), $signed(got[36:5]));
            errors++;
        end
    endfunction
endclass

module tb_nmea_gga_rmc_field_extractor;

    localparam int IDLE_LIMIT = 5000;

    typedef enum int { PS_IDLE, PS_HEADER, PS_GGA, PS_RMC } pstate_e;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        cfg_wen;
    logic [1:0]  cfg_idx;
    logic [7:0]  cfg_wdata;

    field_scoreboard sb;
    bit              hold_off;
    int              idle_cycles;

    // Predictor state
    logic [6:0]  win_lat_lo, win_lat_hi;
    logic [7:0]  win_lng_lo, win_lng_hi;
    pstate_e     pst;
    int unsigned hdr_pos;
    logic [1:0]  hdr_cand;
    int unsigned fld_num;
    longint unsigned acc_whole, acc_frac;
    int unsigned frac_cnt;
    bit          neg, pt, nonempty, stopped;
    logic [7:0]  first_ch;

    byte sentence[$];

    nmea_gga_rmc_field_extractor uut (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic longint unsigned pow10(int unsigned n);
        longint unsigned r = 1;
        for (int i = 0; i < n; i++) r = r * 10;
        return r;
    endfunction

    function automatic logic [31:0] clamp32(longint unsigned mag, bit is_neg);
        if (is_neg) return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'd0 - mag[31:0];
        return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    function automatic logic [31:0] coord_value(longint unsigned lo, longint unsigned hi);
        longint unsigned deg, mins;
        if (neg) return 32'd0;
        deg = acc_whole / 100;
        if (!(deg > lo && deg < hi)) return 32'd0;
        mins = (acc_whole % 100) * pow10(FRAC_DIGITS) + acc_frac * pow10(FRAC_DIGITS - frac_cnt);
        return clamp32(deg * 10000000 + (mins * 10000000) / (60 * pow10(FRAC_DIGITS)), 1'b0);
    endfunction

    function automatic void clear_acc();
        acc_whole = 0; acc_frac = 0; frac_cnt = 0;
        neg = 0; pt = 0; nonempty = 0; stopped = 0; first_ch = 8'd0;
    endfunction

    // Close the current field and note its result, if mapped and non-empty
    function automatic void close_field();
        fmap_t           m;
        logic [31:0]     v;
        longint unsigned fn;
        case (fld_num)
            1: m = '{conv: CONV_INT, qty: QTY_TIME};
            default: m = '{conv: CONV_NONE, qty: QTY_TIME};
        endcase
        if (pst == PS_RMC) begin
            case (fld_num)
                2: m = '{conv: CONV_FLAG, qty: QTY_VALID};
                3: m = '{conv: CONV_LAT, qty: QTY_LAT};
                4: m = '{conv: CONV_FLAG, qty: QTY_LATDIR};
                5: m = '{conv: CONV_LNG, qty: QTY_LNG};
                6: m = '{conv: CONV_FLAG, qty: QTY_LNGDIR};
                7: m = '{conv: CONV_DEC, qty: QTY_SPEED};
                8: m = '{conv: CONV_DEC, qty: QTY_HEADING};
                9: m = '{conv: CONV_INT, qty: QTY_DATE};
                default: ;
            endcase
        end else begin
            case (fld_num)
                2: m = '{conv: CONV_LAT, qty: QTY_LAT};
                3: m = '{conv: CONV_FLAG, qty: QTY_LATDIR};
                4: m = '{conv: CONV_LNG, qty: QTY_LNG};
                5: m = '{conv: CONV_FLAG, qty: QTY_LNGDIR};
                6: m = '{conv: CONV_INT, qty: QTY_QUALITY};
                7: m = '{conv: CONV_INT, qty: QTY_SATS};
                8: m = '{conv: CONV_DEC, qty: QTY_HDOP};
                9: m = '{conv: CONV_DEC, qty: QTY_ALT};
                13: m = '{conv: CONV_INT, qty: QTY_DIFFAGE};
                default: ;
            endcase
        end
        if (m.conv == CONV_NONE || !nonempty) return;
        fn = acc_frac * pow10(FRAC_DIGITS - frac_cnt);
        case (m.conv)
            CONV_INT:  v = clamp32(acc_whole, neg);
            CONV_DEC:  v = clamp32(acc_whole * 1000 + fn / pow10(FRAC_DIGITS - 3), neg);
            CONV_FLAG: v = {24'd0, first_ch};
            CONV_LAT:  v = coord_value(win_lat_lo, win_lat_hi);
            default:   v = coord_value(win_lng_lo, win_lng_hi);
        endcase
        sb.note({3'd0, v, m.qty, pst == PS_RMC});
    endfunction

    // Advance the predictor by one accepted text byte
    function automatic void predict_byte(logic [7:0] c);
        bit delim, ends;
        delim = (c == CH_COMMA || c == CH_STAR || c == CH_CR || c == CH_LF);
        ends  = (c == CH_STAR || c == CH_CR || c == CH_LF);
        if (c == CH_DOLLAR) begin
            pst = PS_HEADER; hdr_pos = 0; hdr_cand = 2'b11; fld_num = 0;
            clear_acc();
            return;
        end
        if (pst == PS_IDLE) return;
        if (pst == PS_HEADER) begin
            if (!delim) begin
                if (hdr_pos < 5) begin
                    if (c != (("GNGGA" >> (8 * (4 - hdr_pos))) & 8'hFF)) hdr_cand[0] = 1'b0;
                    if (c != (("GNRMC" >> (8 * (4 - hdr_pos))) & 8'hFF)) hdr_cand[1] = 1'b0;
                    hdr_pos++;
                end else begin
                    hdr_pos = 6; hdr_cand = 2'b00;
                end
                return;
            end
            if (hdr_pos == 5 && hdr_cand[0]) pst = PS_GGA;
            else if (hdr_pos == 5 && hdr_cand[1]) pst = PS_RMC;
            else pst = PS_IDLE;
            if (ends) pst = PS_IDLE;
            fld_num = 1;
            clear_acc();
            return;
        end
        if (!delim) begin
            if (!nonempty) begin
                nonempty = 1; first_ch = c;
                if (c == CH_MINUS) begin
                    neg = 1;
                    return;
                end
                if (c == CH_PLUS) return;
            end
            if (stopped) return;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                if (pt) begin
                    if (frac_cnt < FRAC_DIGITS) begin
                        acc_frac = acc_frac * 10 + (c - CH_ZERO);
                        frac_cnt++;
                    end
                end else if (acc_whole > (WHOLE_CAP - (c - CH_ZERO)) / 10) begin
                    acc_whole = WHOLE_CAP;
                end else begin
                    acc_whole = acc_whole * 10 + (c - CH_ZERO);
                end
            end else if (c == CH_POINT && !pt) begin
                pt = 1;
            end else begin
                stopped = 1;
            end
            return;
        end
        close_field();
        if (fld_num < 15) fld_num++;
        clear_acc();
        if (ends) pst = PS_IDLE;
    endfunction

    // Offer one byte; drop valid only while idling before it
    task automatic send_byte(logic [7:0] c);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge aclk); while (!s_tready);
        predict_byte(c);
    endtask

    task automatic send_text(string t);
        for (int i = 0; i < t.len(); i++) send_byte(t[i]);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        cfg_wen   <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        case (idx)
            CFG_LAT_LOW:  win_lat_lo = val[6:0];
            CFG_LAT_HIGH: win_lat_hi = val[6:0];
            CFG_LNG_LOW:  win_lng_lo = val;
            default:      win_lng_hi = val;
        endcase
        @(posedge aclk);
    endtask

    // Random numeric text, mostly well formed
    function automatic string rand_number();
        string s;
        int    n;
        s = "";
        case ($urandom_range(0, 9))
            0: s = "-";
            1: s = "+";
            default: ;
        endcase
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 5);
        for (int i = 0; i < n; i++) s = {s, string'(byte'("0" + $urandom_range(0, 9)))};
        if ($urandom_range(0, 2) != 0) begin
            s = {s, "."};
            n = $urandom_range(0, 9);
            for (int i = 0; i < n; i++) s = {s, string'(byte'("0" + $urandom_range(0, 9)))};
        end
        if ($urandom_range(0, 12) == 0) s = {s, "x9"};
        return s;
    endfunction

    function automatic string rand_coord(bit is_lng);
        string s;
        int    d;
        d = is_lng ? $urandom_range(0, 181) : $urandom_range(0, 91);
        s = $sformatf(is_lng ? "%03d%02d.%0d" : "%02d%02d.%0d", d, $urandom_range(0, 59),
                      $urandom_range(0, 9999999));
        return s;
    endfunction

    function automatic string rand_field(int pos, bit is_rmc);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return "";
        if (r == 1) return string'(byte'($urandom_range(32, 126)));
        if ((is_rmc && (pos == 3 || pos == 5)) || (!is_rmc && (pos == 2 || pos == 4)))
            return rand_coord(is_rmc ? pos == 5 : pos == 4);
        if ((is_rmc && pos inside {2, 4, 6}) || (!is_rmc && pos inside {3, 5}))
            return ($urandom_range(0, 1) != 0) ? "N" : "W";
        return rand_number();
    endfunction

    // Random sentence: good headers mostly, random content and endings
    task automatic send_sentence();
        string s;
        bit    is_rmc;
        int    nf;
        is_rmc = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0: s = "$GPGGA";
            1: s = "$GNGGAX";
            2: s = "$GNR";
            default: s = is_rmc ? "$GNRMC" : "$GNGGA";
        endcase
        nf = $urandom_range(1, 17);
        for (int i = 1; i <= nf; i++) s = {s, ",", rand_field(i, is_rmc)};
        case ($urandom_range(0, 3))
            0: s = {s, "*5A\r\n"};
            1: s = {s, "\n"};
            2: s = {s, "\r"};
            default: s = {s, "*"};
        endcase
        send_text(s);
    endtask

    // Result side: random stalls, one long hold-off
    initial begin
        int gap;
        bit stalled_once;
        stalled_once = 0;
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if (hold_off && !stalled_once) begin
                gap = 400;
                stalled_once = 1;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check(m_tdata);
        end
    end

    // Watchdog on cycles with no item moving
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        sb = new();
        hold_off = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'd0;
        cfg_wen = 1'b0;
        cfg_idx = CFG_LAT_LOW;
        cfg_wdata = 8'd0;
        win_lat_lo = LAT_LOW_RST; win_lat_hi = LAT_HIGH_RST;
        win_lng_lo = LNG_LOW_RST; win_lng_hi = LNG_HIGH_RST;
        pst = PS_IDLE; hdr_pos = 0; hdr_cand = 0; fld_num = 0;
        clear_acc();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: both maps, extremes, signs, empty fields, bad header
        send_text("x$GNRMC,-123.5,A,1230.5,N,07730.25,E,1.2345,-0.5,999999999999,,,,\r");
        send_text("$GNGGA,+42,-1230,S,97000,W,1,12x,0.9,-3000000.0,,,,77,,,,,");
        send_text("\xff\x00$GNGGAA,1,2*$GNXYZ,1,2\n$GNGGA*");
        wait_drained();

        // Window extremes and odd settings
        write_reg(CFG_LAT_LOW, 8'd0);
        write_reg(CFG_LAT_HIGH, 8'd90);
        write_reg(CFG_LNG_LOW, 8'd0);
        write_reg(CFG_LNG_HIGH, 8'd180);
        for (int k = 0; k < 3; k++) begin
            // stall the result side while the first batch is still streaming
            if (k == 0) hold_off = 1;
            for (int i = 0; i < 3; i++) send_sentence();
            wait_drained();
            write_reg(CFG_LAT_LOW, 8'($urandom_range(0, 255)));
            write_reg(CFG_LAT_HIGH, (k == 1) ? 8'd127 : 8'($urandom_range(0, 90)));
            write_reg(CFG_LNG_LOW, (k == 2) ? 8'd180 : 8'($urandom_range(0, 90)));
            write_reg(CFG_LNG_HIGH, (k == 1) ? 8'd255 : 8'($urandom_range(90, 180)));
        end
        for (int i = 0; i < 50; i++) send_byte(8'($urandom_range(0, 255)));
        wait_drained();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
